/* rtl/pbme_pkg.sv */
// ----------------------------------------------------------------------------
// pbme_pkg
// Shared constants and types for the profile bin mean/error core.
// ----------------------------------------------------------------------------
package pbme_pkg;

    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [15:0] MIN_ENTRIES_RESET = 16'd2;
    localparam logic        ERROR_MODE_RESET  = 1'b0;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_ENTRIES = 1'b0;
    localparam logic REG_ERROR_MODE  = 1'b1;

    // pipeline control handed to each arithmetic unit
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

/* rtl/pbme_udiv_pipe.sv */
// ----------------------------------------------------------------------------
// pbme_udiv_pipe
// Unsigned restoring divider, one quotient bit per register stage, with a
// sideband word and the divisor carried alongside each beat.
// ----------------------------------------------------------------------------
module pbme_udiv_pipe #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbme_pkg::pipe_ctl_t ctl_in,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   side,
    output logic                out_valid,
    output logic [NUM_W-1:0]    quot,
    output logic [DEN_W-1:0]    den_out,
    output logic [SIDE_W-1:0]   side_out
);

    logic              valid_reg [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [NUM_W-1:0]  nq_reg    [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              v_in;
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = ctl_in.valid;
            assign rem_in  = '0;
            assign nq_in   = num;
            assign den_in  = den;
            assign side_in = side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign take  = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ctl_in.advance) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl_in.advance) begin
                rem_reg[k]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_reg[k]   <= {nq_in[NUM_W-2:0], take};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign quot      = nq_reg[NUM_W-1];
    assign den_out   = den_reg[NUM_W-1];
    assign side_out  = side_reg[NUM_W-1];

endmodule

/* rtl/pbme_isqrt_pipe.sv */
// ----------------------------------------------------------------------------
// pbme_isqrt_pipe
// Integer square root, digit by digit, one root bit per register stage.
// ----------------------------------------------------------------------------
module pbme_isqrt_pipe #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pbme_pkg::pipe_ctl_t    ctl_in,
    input  logic [IN_W-1:0]        radicand,
    input  logic [SIDE_W-1:0]      side,
    output logic                   out_valid,
    output logic [(IN_W+1)/2-1:0]  root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int RW = (IN_W + 1) / 2;
    localparam int PW = 2 * RW;

    logic              valid_reg [RW];
    logic [RW:0]       rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic [PW-1:0]     y_reg     [RW];
    logic [SIDE_W-1:0] side_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              v_in;
        logic [RW:0]       rem_in;
        logic [RW-1:0]     root_in;
        logic [PW-1:0]     y_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+2:0]     cur;
        logic [RW+2:0]     trial;
        logic [RW+2:0]     diff;
        logic              take;

        if (k == 0) begin : g_first
            assign v_in    = ctl_in.valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign y_in    = PW'(radicand);
            assign side_in = side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign y_in    = y_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign cur   = {rem_in, y_in[PW-1:PW-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ctl_in.advance) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl_in.advance) begin
                rem_reg[k]  <= take ? diff[RW:0] : cur[RW:0];
                root_reg[k] <= {root_in[RW-2:0], take};
                y_reg[k]    <= {y_in[PW-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

/* rtl/profile_bin_mean_error_core.sv */
// ----------------------------------------------------------------------------
// profile_bin_mean_error_core
// Finalizes profile histogram bins: mean and standard error or spread.
// ----------------------------------------------------------------------------
// One bin enters per clock cycle and one result leaves per cycle; a stalled
// output holds the whole pipeline. The bin-mean and variance dividers take
// one stage per bit of XW = 48 + min(COUNT_BITS,16) + FRACTION_BITS, the
// variance numerator width; the square root and the final divide by count
// take one stage per bit of RW = (XW+1)/2. Bins below min_entries give zero
// mean and error.
module profile_bin_mean_error_core #(
    parameter int COUNT_BITS    = pbme_pkg::COUNT_BITS_DEF,
    parameter int FRACTION_BITS = pbme_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // weighted_sum[31:0], square_sum[79:32], entry_count[95:80]
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // bin_mean[31:0], bin_error[63:32]
    output logic [1:0]  m_tuser    // bin_valid[0], dropped_nonzero[1]
);

    localparam int NW   = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam int PAW  = 48 + NW;
    localparam int XW   = PAW + FRACTION_BITS;
    localparam int RW   = (XW + 1) / 2;
    localparam int XS_W = XW + 2;
    localparam int QS_W = 32 + NW + 3;
    localparam int RS_W = 35;

    // ---------------- configuration ----------------
    logic [15:0] min_entries_reg;
    logic        error_mode_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_entries_reg <= pbme_pkg::MIN_ENTRIES_RESET;
            error_mode_reg  <= pbme_pkg::ERROR_MODE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == pbme_pkg::REG_MIN_ENTRIES) begin
                min_entries_reg <= pwdata[15:0];
            end else begin
                error_mode_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == pbme_pkg::REG_ERROR_MODE) ? {31'b0, error_mode_reg}
                                                           : {16'b0, min_entries_reg};

    // ---------------- flow control ----------------
    logic                m_tvalid_reg;
    logic                advance;
    pbme_pkg::pipe_ctl_t ctl_x, ctl_q, ctl_r;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // ---------------- stage 1: unpack, products ----------------
    logic [31:0]     in_sum;
    logic [47:0]     in_sq;
    logic [NW-1:0]   in_n;
    logic [15:0]     least;
    logic            in_neg;
    logic [31:0]     in_mag;

    assign in_sum = s_tdata[31:0];
    assign in_sq  = s_tdata[79:32];
    assign in_n   = s_tdata[80 +: NW];
    assign least  = (min_entries_reg == 16'd0) ? 16'd1 : min_entries_reg;
    assign in_neg = in_sum[31];
    assign in_mag = in_neg ? (~in_sum + 32'd1) : in_sum;

    logic            s1_valid_reg;
    logic [PAW-1:0]  s1_prod_a_reg;
    logic [63:0]     s1_prod_b_reg;
    logic [31:0]     s1_mag_reg;
    logic [NW-1:0]   s1_n_reg;
    logic            s1_neg_reg;
    logic            s1_ok_reg;
    logic            s1_drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_prod_a_reg <= PAW'(in_sq) * PAW'(in_n);
            s1_prod_b_reg <= 64'(in_mag) * 64'(in_mag);
            s1_mag_reg    <= in_mag;
            s1_n_reg      <= in_n;
            s1_neg_reg    <= in_neg;
            s1_ok_reg     <= (16'(in_n) >= least);
            s1_drop_reg   <= (16'(in_n) < least) && (in_sum != 32'd0);
        end
    end

    // ---------------- stage 2: variance numerator ----------------
    logic [XW-1:0] num_a, num_b;

    assign num_a = {s1_prod_a_reg, {FRACTION_BITS{1'b0}}};
    assign num_b = XW'(s1_prod_b_reg);

    logic            s2_valid_reg;
    logic [XW-1:0]   s2_x_reg;
    logic [31:0]     s2_mag_reg;
    logic [NW-1:0]   s2_n_reg;
    logic            s2_neg_reg;
    logic            s2_ok_reg;
    logic            s2_drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_x_reg    <= (num_a < num_b) ? (num_b - num_a) : (num_a - num_b);
            s2_mag_reg  <= s1_mag_reg;
            s2_n_reg    <= s1_n_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_drop_reg <= s1_drop_reg;
        end
    end

    // ---------------- X / n and mean, side by side ----------------
    logic              xd_valid, md_valid;
    logic [XW-1:0]     xd_quot, md_quot;
    logic [NW-1:0]     xd_den, md_den;
    logic [XS_W-1:0]   xd_side;
    logic              md_side;

    assign ctl_x.advance = advance;
    assign ctl_x.valid   = s2_valid_reg;

    pbme_udiv_pipe #(.NUM_W(XW), .DEN_W(NW), .SIDE_W(XS_W)) u_div_var (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_x),
        .num       (s2_x_reg),
        .den       (s2_n_reg),
        .side      ({s2_x_reg, s2_ok_reg, s2_drop_reg}),
        .out_valid (xd_valid),
        .quot      (xd_quot),
        .den_out   (xd_den),
        .side_out  (xd_side)
    );

    pbme_udiv_pipe #(.NUM_W(XW), .DEN_W(NW), .SIDE_W(1)) u_div_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_x),
        .num       (XW'(s2_mag_reg)),
        .den       (s2_n_reg),
        .side      (s2_neg_reg),
        .out_valid (md_valid),
        .quot      (md_quot),
        .den_out   (md_den),
        .side_out  (md_side)
    );

    // ---------------- square root ----------------
    logic [XW-1:0]   radicand;
    logic            sq_valid;
    logic [RW-1:0]   sq_root;
    logic [QS_W-1:0] sq_side;

    // spread mode takes the root of X itself
    assign radicand      = error_mode_reg ? xd_side[XS_W-1:2] : xd_quot;
    assign ctl_q.advance = advance;
    assign ctl_q.valid   = xd_valid;

    pbme_isqrt_pipe #(.IN_W(XW), .SIDE_W(QS_W)) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_q),
        .radicand  (radicand),
        .side      ({md_quot[31:0], xd_den, xd_side[1:0], md_side}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- root / n ----------------
    logic            rd_valid;
    logic [RW-1:0]   rd_quot;
    logic [NW-1:0]   rd_den;
    logic [RS_W-1:0] rd_side;

    assign ctl_r.advance = advance;
    assign ctl_r.valid   = sq_valid;

    pbme_udiv_pipe #(.NUM_W(RW), .DEN_W(NW), .SIDE_W(RS_W)) u_div_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_r),
        .num       (sq_root),
        .den       (sq_side[3 +: NW]),
        .side      ({sq_side[QS_W-1 -: 32], sq_side[2:0]}),
        .out_valid (rd_valid),
        .quot      (rd_quot),
        .den_out   (rd_den),
        .side_out  (rd_side)
    );

    // ---------------- output register ----------------
    logic [31:0] mq;
    logic        r_ok, r_drop, r_neg, r_sat;
    logic [31:0] mean_val, err_val;

    assign mq       = rd_side[34:3];
    assign r_ok     = rd_side[2];
    assign r_drop   = rd_side[1];
    assign r_neg    = rd_side[0];
    assign r_sat    = (rd_quot >> 32) != '0;
    assign mean_val = r_neg ? (~mq + 32'd1) : mq;
    assign err_val  = r_sat ? 32'hFFFF_FFFF : rd_quot[31:0];

    logic [63:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= rd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= r_ok ? {err_val, mean_val} : 64'd0;
            m_tuser_reg <= {r_drop & ~r_ok, r_ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- checks ----------------
    a_units_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        xd_valid == md_valid)
        else $error("variance and mean dividers out of step");

    a_denominator_match: assert property (@(posedge aclk) disable iff (!aresetn)
        xd_valid |-> xd_den == md_den)
        else $error("dividers carry different counts");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("invalid bin with nonzero result");

    a_valid_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("valid bin flagged as dropped");

    a_root_den_used: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid && rd_side[2] |-> rd_den != '0)
        else $error("valid bin divided by zero count");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives profile bins into profile_bin_mean_error_core and checks each result
// beat (mean, error, valid, dropped flags) against a bit-exact predictor or a
// typed result, over several min_entries/error_mode settings, with random idling.
// ----------------------------------------------------------------------------
module tb;

    localparam int FRAC      = pbme_pkg::FRACTION_BITS_DEF;
    localparam int SETTLE    = 200;   // beyond the full pipeline latency
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_LEN  = 500;

    typedef struct {
        logic [31:0] mean;
        logic [31:0] err;
        logic        valid;
        logic        dropped;
    } bin_res_t;

    typedef struct {
        logic [31:0] sum;
        logic [47:0] sq;
        logic [15:0] cnt;
        logic        typed;  // expected result below is given by hand
        bin_res_t    res;
    } bin_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // weighted_sum[31:0], square_sum[79:32], entry_count[95:80]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // bin_mean[31:0], bin_error[63:32]
    logic [1:0]  m_tuser;   // bin_valid[0], dropped_nonzero[1]

    profile_bin_mean_error_core uut (.*);

    logic [15:0] cur_min_entries;
    logic        cur_error_mode;
    bin_res_t    pending_bins[$];
    int          fail_cnt;
    int          beats_in;
    int          idle_cycles;
    bit          hold_done;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic bin_res_t finalize_bin(logic [31:0] sum, logic [47:0] sq,
                                              logic [15:0] cnt);
        bin_res_t     r;
        logic [15:0]  least;
        logic         neg;
        logic [127:0] mag, n, a, b, x, root, e, mq;
        least = (cur_min_entries == 0) ? 16'd1 : cur_min_entries;
        neg = sum[31];
        mag = neg ? 128'(32'((~sum) + 32'd1)) : 128'(sum);
        if (neg && mag[31:0] == 0)
            mag = 128'h8000_0000;
        n = 128'(cnt);
        if (cnt < least) begin
            r.mean = '0;
            r.err = '0;
            r.valid = 1'b0;
            r.dropped = (sum != 0);
            return r;
        end
        mq = mag / n;
        r.mean = neg ? (~mq[31:0]) + 32'd1 : mq[31:0];
        a = (128'(sq) * n) << FRAC;
        b = mag * mag;
        x = (a < b) ? b - a : a - b;
        root = cur_error_mode ? 128'(isqrt128(x)) : 128'(isqrt128(x / n));
        e = root / n;
        r.err = (e > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        r.valid = 1'b1;
        r.dropped = 1'b0;
        return r;
    endfunction

    task automatic apb_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == pbme_pkg::REG_MIN_ENTRIES)
            cur_min_entries = value[15:0];
        else
            cur_error_mode = value[0];
    endtask

    task automatic set_mode(logic [15:0] min_e, logic mode);
        while (pending_bins.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        apb_write(pbme_pkg::REG_MIN_ENTRIES, 32'(min_e));
        apb_write(pbme_pkg::REG_ERROR_MODE, 32'(mode));
    endtask

    // offer one bin, hold it until accepted, then maybe leave a gap
    task automatic send_bin(bin_row_t row);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {row.cnt, row.sq, row.sum};
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        pending_bins.push_back(row.typed ? row.res :
                               finalize_bin(row.sum, row.sq, row.cnt));
        gap = 0;
        if ((beats_in / 200) % 2 == 1)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
        else if ($urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(int num);
        bin_row_t    row;
        logic [63:0] mag;
        int          pick;
        for (int k = 0; k < num; k++) begin
            row.typed = 1'b0;
            row.sum = $urandom();
            if ($urandom_range(0, 3) == 0)
                row.sum = 32'($signed($urandom_range(0, 2000)) - 1000);
            pick = $urandom_range(0, 3);
            if (pick < 2)
                row.cnt = 16'($urandom_range(0, 8));
            else if (pick == 2)
                row.cnt = 16'($urandom());
            else if (cur_min_entries > 16'd65533)
                row.cnt = 16'(16'hFFFF - $urandom_range(0, 2));
            else
                row.cnt = 16'(cur_min_entries + $urandom_range(0, 2)
                              - (cur_min_entries > 0));
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                row.sq = 48'({$urandom(), $urandom()});
            end else if (pick == 1) begin
                row.sq = 48'($urandom_range(0, 1000));
            end else begin
                // roughly consistent with the sum, plus some spread
                mag = row.sum[31] ? 64'(-$signed(row.sum)) : 64'(row.sum);
                row.sq = 48'(((mag * mag) >> FRAC) / ((row.cnt == 0) ? 1 : row.cnt))
                         + 48'($urandom());
            end
            send_bin(row);
        end
        s_tvalid <= 1'b0;
    endtask

    bin_row_t directed_rows[] = '{
        '{32'd0,          48'd0,                16'd0,     1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'd5,          48'd0,                16'd0,     1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
        '{32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF,   16'd1,     1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
        '{32'h8000_0000,  48'd0,                16'd1,     1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
        '{32'd0,          48'd0,                16'd2,     1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
        '{32'h0004_0000,  48'h0008_0000,        16'd2,     1'b1, '{32'h0002_0000, 32'd0, 1'b1, 1'b0}},
        '{32'h7FFF_FFFF,  48'd0,                16'd2,     1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'h8000_0000,  48'd0,                16'd2,     1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'h8000_0000,  48'hFFFF_FFFF_FFFF,   16'hFFFF,  1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'h7FFF_FFFF,  48'hFFFF_FFFF_FFFF,   16'hFFFF,  1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'd0,          48'hFFFF_FFFF_FFFF,   16'd2,     1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'hFFF0_0000,  48'd1,                16'd3,     1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'h0010_0000,  48'h0123_4567_89AB,   16'd7,     1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'hAAAA_AAAA,  48'h5555_5555_5555,   16'h5555,  1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}},
        '{32'h5555_5555,  48'hAAAA_AAAA_AAAA,   16'hAAAA,  1'b0, '{32'd0, 32'd0, 1'b0, 1'b0}}
    };

    // result side: check each beat, stall at random, one long hold-off
    int gap_left;
    always @(posedge aclk) begin
        bin_res_t want;
        if (!aresetn) begin
            gap_left <= 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_bins.size() == 0) begin
                    $display("%0t: unexpected result beat %h/%b", $time, m_tdata, m_tuser);
                    fail_cnt++;
                end else begin
                    want = pending_bins.pop_front();
                    if (m_tdata[31:0] !== want.mean) begin
                        $display("%0t: bin_mean exp %h got %h", $time, want.mean, m_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[63:32] !== want.err) begin
                        $display("%0t: bin_error exp %h got %h", $time, want.err, m_tdata[63:32]);
                        fail_cnt++;
                    end
                    if (m_tuser[0] !== want.valid) begin
                        $display("%0t: bin_valid exp %b got %b", $time, want.valid, m_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_tuser[1] !== want.dropped) begin
                        $display("%0t: dropped_nonzero exp %b got %b", $time, want.dropped,
                                 m_tuser[1]);
                        fail_cnt++;
                    end
                end
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_in >= 700) begin
                hold_done <= 1'b1;
                gap_left <= HOLD_LEN;
                m_tready <= 1'b0;
            end else if ((beats_in / 300) % 2 == 0 && $urandom_range(0, 4) == 0) begin
                gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stop when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog timeout", $time);
            $display("[profile_bin_mean_error_core] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        fail_cnt = 0;
        beats_in = 0;
        idle_cycles = 0;
        hold_done = 1'b0;
        cur_min_entries = pbme_pkg::MIN_ENTRIES_RESET;
        cur_error_mode  = pbme_pkg::ERROR_MODE_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_bin(directed_rows[i]);
        s_tvalid <= 1'b0;
        send_random(300);

        set_mode(16'd1, 1'b1);
        send_random(350);
        set_mode(16'hFFFF, 1'b0);
        send_random(150);
        set_mode(16'd0, 1'b1);
        send_random(300);
        set_mode(16'($urandom_range(3, 40000)), 1'b0);
        send_random(250);
        set_mode(16'd3, 1'b1);
        send_random(150);

        while (pending_bins.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (fail_cnt == 0)
            $display("[profile_bin_mean_error_core] OK");
        else
            $display("[profile_bin_mean_error_core] ERROR");
        $finish;
    end
endmodule
